@@ src/phr_pkg.sv @@
// Shared types and constants for the pixel hue rotator.
package phr_pkg;

  localparam int unsigned QuoW = 9;
  localparam int unsigned RemW = 8;

  localparam logic [16:0] Mod360Mul   = 17'd46604;
  localparam int unsigned Mod360Shift = 24;
  localparam logic [14:0] Div60Mul    = 15'd17477;
  localparam int unsigned Div60Shift  = 20;

  localparam logic [2:0] Sec0 = 3'd0;
  localparam logic [2:0] Sec1 = 3'd1;
  localparam logic [2:0] Sec2 = 3'd2;
  localparam logic [2:0] Sec3 = 3'd3;
  localparam logic [2:0] Sec4 = 3'd4;
  localparam logic [2:0] Sec5 = 3'd5;

  typedef struct packed {
    logic [31:0]        pixel;
    logic signed [15:0] shift;
    logic               bypass;
    logic [7:0]         lo;
    logic [7:0]         c;
  } phr_item_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] bits;
    logic [QuoW-1:0] quo;
  } phr_div_t;

endpackage

@@ src/phr_front.sv @@
// Chroma, dominant-channel sector and hue numerator for one pixel.
module phr_front (
  input  logic [31:0]         pixel_i,
  input  logic signed [15:0]  shift_i,
  output phr_pkg::phr_item_t  item_o,
  output phr_pkg::phr_div_t   div_o
);

  logic [7:0]  r, g, b, hi, lo, c;
  logic [10:0] c6, x;
  logic [16:0] n;

  assign r = pixel_i[23:16];
  assign g = pixel_i[15:8];
  assign b = pixel_i[7:0];

  always_comb begin
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
  end

  assign c  = hi - lo;
  assign c6 = ({3'b0, c} << 2) + ({3'b0, c} << 1);

  always_comb begin
    priority if (hi == r) begin
      if (g >= b) x = {3'b0, g} - {3'b0, b};
      else        x = c6 - ({3'b0, b} - {3'b0, g});
    end else if (hi == g) begin
      x = {3'b0, b} + {2'b0, c, 1'b0} - {3'b0, r};
    end else begin
      x = {3'b0, r} + {1'b0, c, 2'b0} - {3'b0, g};
    end
  end

  assign n = {6'b0, x} * 17'd60;

  assign item_o.pixel  = pixel_i;
  assign item_o.shift  = shift_i;
  assign item_o.bypass = (shift_i == 16'sd0) || (c == 8'd0);
  assign item_o.lo     = lo;
  assign item_o.c      = c;

  assign div_o.rem  = n[16:9];
  assign div_o.bits = n[8:0];
  assign div_o.quo  = '0;

endmodule

@@ src/phr_div_cell.sv @@
// One restoring-division cell: one quotient bit per cell, registered.
module phr_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  phr_pkg::phr_item_t item_i,
  input  phr_pkg::phr_div_t  div_i,
  output logic               valid_o,
  output phr_pkg::phr_item_t item_o,
  output phr_pkg::phr_div_t  div_o
);

  logic                    valid_q;
  phr_pkg::phr_item_t      item_q;
  phr_pkg::phr_div_t       div_d, div_q;
  logic [phr_pkg::RemW:0]  t;
  logic                    ge;

  assign t  = {div_i.rem, div_i.bits[phr_pkg::QuoW-1]};
  assign ge = t >= {1'b0, item_i.c};

  always_comb begin
    div_d.rem  = ge ? phr_pkg::RemW'(t - {1'b0, item_i.c}) : t[phr_pkg::RemW-1:0];
    div_d.bits = {div_i.bits[phr_pkg::QuoW-2:0], 1'b0};
    div_d.quo  = {div_i.quo[phr_pkg::QuoW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_i;
      div_q  <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign div_o   = div_q;

endmodule

@@ src/phr_rebuild.sv @@
// Hue rotation, sector split and RGB rebuild over three registered stages.
module phr_rebuild (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  phr_pkg::phr_item_t item_i,
  input  logic [8:0]         hue_i,
  output logic               valid_o,
  output logic [31:0]        pixel_o
);

  logic signed [16:0] sum;
  logic [16:0]        abs_v;
  logic [33:0]        prod1;
  logic               v1_q, v2_q, v3_q;
  phr_pkg::phr_item_t it1_q, it2_q;
  logic [16:0]        abs_q;
  logic [33:0]        prod1_q;

  logic [8:0]  q;
  logic [8:0]  hp;
  logic [2:0]  sec;
  logic [6:0]  t;
  logic [5:0]  ramp;
  logic [13:0] p2;
  logic [2:0]  sec_q;
  logic [13:0] p2_q;

  logic [28:0] prod3;
  logic [7:0]  cc, ro, go, bo;
  logic [31:0] pix_d, pix_q;

  assign sum   = $signed({8'b0, hue_i}) + $signed({item_i.shift[15], item_i.shift});
  assign abs_v = sum[16] ? 17'(-sum) : 17'(sum);
  assign prod1 = {17'b0, abs_v} * {17'b0, phr_pkg::Mod360Mul};

  assign q  = prod1_q[phr_pkg::Mod360Shift +: 9];
  assign hp = 9'(abs_q - {8'b0, q} * 17'd360);

  always_comb begin
    priority if (hp >= 9'd300) sec = phr_pkg::Sec5;
    else if (hp >= 9'd240)     sec = phr_pkg::Sec4;
    else if (hp >= 9'd180)     sec = phr_pkg::Sec3;
    else if (hp >= 9'd120)     sec = phr_pkg::Sec2;
    else if (hp >= 9'd60)      sec = phr_pkg::Sec1;
    else                       sec = phr_pkg::Sec0;
  end

  assign t    = 7'(hp - {7'b0, sec[2:1]} * 9'd120);
  assign ramp = (t >= 7'd60) ? 6'(7'd120 - t) : t[5:0];
  assign p2   = {6'b0, it1_q.c} * {8'b0, ramp};

  assign prod3 = {15'b0, p2_q} * {14'b0, phr_pkg::Div60Mul};
  assign cc    = prod3[phr_pkg::Div60Shift +: 8];

  always_comb begin
    unique case (sec_q)
      phr_pkg::Sec0: begin ro = it2_q.c; go = cc;      bo = 8'd0;    end
      phr_pkg::Sec1: begin ro = cc;      go = it2_q.c; bo = 8'd0;    end
      phr_pkg::Sec2: begin ro = 8'd0;    go = it2_q.c; bo = cc;      end
      phr_pkg::Sec3: begin ro = 8'd0;    go = cc;      bo = it2_q.c; end
      phr_pkg::Sec4: begin ro = cc;      go = 8'd0;    bo = it2_q.c; end
      default:       begin ro = it2_q.c; go = 8'd0;    bo = cc;      end
    endcase
    if (it2_q.bypass) begin
      pix_d = it2_q.pixel;
    end else begin
      pix_d = {it2_q.pixel[31:24], 8'(ro + it2_q.lo), 8'(go + it2_q.lo),
               8'(bo + it2_q.lo)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q   <= item_i;
      abs_q   <= abs_v;
      prod1_q <= prod1;
      it2_q   <= it1_q;
      sec_q   <= sec;
      p2_q    <= p2;
      pix_q   <= pix_d;
    end
  end

  assign valid_o = v3_q;
  assign pixel_o = pix_q;

endmodule

@@ src/pixel_hue_rotator_core.sv @@
// Pixel hue rotator top level: analysis stage, divider chain and rebuild stages.
// Accepts one ARGB pixel and a signed hue shift per clock while not stalled and
// returns the hue-rotated pixel, one pixel per clock sustained unless the output
// stalls; each pixel passes the analysis stage, the nine-cell divider chain that
// forms the hue quotient (one bit per cell) and three rebuild stages. The whole
// pipeline holds while a finished pixel is stalled at the output.
module pixel_hue_rotator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        pixel_in_i,
  input  logic signed [15:0] hue_shift_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        pixel_out_o
);

  localparam int unsigned NumCells = phr_pkg::QuoW;

  logic               en;
  phr_pkg::phr_item_t fr_item, s0_item_q;
  phr_pkg::phr_div_t  fr_div, s0_div_q;
  logic               s0_valid_q;

  logic               cv [NumCells+1];
  phr_pkg::phr_item_t ci [NumCells+1];
  phr_pkg::phr_div_t  cd [NumCells+1];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  phr_front u_front (
    .pixel_i (pixel_in_i),
    .shift_i (hue_shift_i),
    .item_o  (fr_item),
    .div_o   (fr_div)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_item_q <= fr_item;
      s0_div_q  <= fr_div;
    end
  end

  assign cv[0] = s0_valid_q;
  assign ci[0] = s0_item_q;
  assign cd[0] = s0_div_q;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    phr_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[k]),
      .item_i  (ci[k]),
      .div_i   (cd[k]),
      .valid_o (cv[k+1]),
      .item_o  (ci[k+1]),
      .div_o   (cd[k+1])
    );
  end

  phr_rebuild u_rebuild (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv[NumCells]),
    .item_i  (ci[NumCells]),
    .hue_i   (cd[NumCells].quo),
    .valid_o (out_valid_o),
    .pixel_o (pixel_out_o)
  );

  a_gray_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q && (s0_item_q.c == 8'd0) |-> s0_item_q.bypass)
    else $error("gray pixel not marked for bypass");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[NumCells] && !ci[NumCells].bypass |-> cd[NumCells].quo < 9'd360)
    else $error("hue quotient out of range");

  a_rem_below_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[NumCells] && !ci[NumCells].bypass |-> cd[NumCells].rem < ci[NumCells].c)
    else $error("divider remainder not below chroma");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(cd[NumCells].quo))
    else $error("divider chain moved during hold");

endmodule
